// ===== rtl/lir_pkg.sv =====
// lir_pkg: shared types, widths and codes for the linear interpolation resampler
// used by the channel interfaces, the lane and merge stages and the top level
package lir_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int STEP_W        = 20;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_RUN_DEF   = 16;

   // lane quotient width, independent of the fraction width
   localparam int Q_W = SAMPLE_W + 7;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE = CSR_IDX_W'(1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       run_last;
   } rsp_word_type;

endpackage

// ===== rtl/lir_req_if.sv =====
// lir_req_if: input frame channel, valid/ready with one stereo sample pair
// depends on lir_pkg
interface lir_req_if;
   import lir_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/lir_rsp_if.sv =====
// lir_rsp_if: result channel, valid/ready with one interpolated frame and run marker
// depends on lir_pkg
interface lir_rsp_if;
   import lir_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   logic                       run_last;

   modport source (output valid, output out_left, output out_right, output run_last,
                   input ready);
   modport sink   (input valid, input out_left, input out_right, input run_last,
                   output ready);
endinterface

// ===== rtl/lir_csr_if.sv =====
// lir_csr_if: configuration write channel, valid/ready with register index and data
// depends on lir_pkg
interface lir_csr_if;
   import lir_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/linear_interp_resampler_top.sv =====
// linear_interp_resampler_top: linear interpolation sample rate converter
// depends on lir_pkg, the channel interfaces, lir_lane and lir_merge
//
// Usage: req carries one input frame (left and right sample) per word, rsp carries
// interpolated frames, csr writes phase_step (index 0, unsigned Q16 by default) and
// stereo_mode (index 1). csr is always ready; write it only while the block is idle.
// Each accepted frame yields 0 to MAX_RUN result words. A frame that yields none is
// absorbed in the accept cycle. Otherwise the state register moves to run, then the
// first result is loaded into the output register and the others follow one per
// cycle unless rsp stalls; the left and right lanes work side by side and
// the merge stage clamps and packs each result, one result a cycle being the bound.
// The last result of each frame carries run_last. A new frame is taken once the last
// result of the previous one is in the output register, even while it waits.
// When rsp stalls, the output register holds its word and the run pauses.
// Reset (synchronous, active high) clears the phase and the stored previous frame to
// zero, sets phase_step to one and stereo mode on, and empties the output register.
module linear_interp_resampler_top #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF,
   parameter int MAX_RUN   = lir_pkg::MAX_RUN_DEF
) (
   input logic       clock,
   input logic       reset,
   lir_req_if.sink   req_port,
   lir_rsp_if.source rsp_port,
   lir_csr_if.sink   csr_port
);
   import lir_pkg::*;

   localparam int PH_W  = FRAC_BITS + 4;
   localparam int SUM_W = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
   localparam int CNT_W = $clog2(MAX_RUN);
   localparam logic [PH_W-1:0]  PH_ONE  = {4'b0001, {FRAC_BITS{1'b0}}};
   localparam logic [PH_W-1:0]  PH_MAX  = '1;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_RUN - 1);

   state_type                  state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       stereo_ff, stereo_in;
   logic [PH_W-1:0]            phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] prev_left_ff, prev_left_in;
   logic signed [SAMPLE_W-1:0] prev_right_ff, prev_right_in;
   logic signed [SAMPLE_W-1:0] cur_left_ff, cur_left_in;
   logic signed [SAMPLE_W-1:0] cur_right_ff, cur_right_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_word_type               rsp_word_ff, rsp_word_in;

   logic                       req_take;
   logic                       emit;
   logic                       last;
   logic                       phase_whole;
   logic [SUM_W-1:0]           sum;
   logic [PH_W-1:0]            phase_sat;
   logic signed [Q_W-1:0]      quot_left;
   logic signed [Q_W-1:0]      quot_right;

   function automatic logic [PH_W-1:0] wrap_phase(input logic [PH_W-1:0] ph);
      // a run cut short by the cap leaves the phase below one: it restarts at zero
      return (ph >= PH_ONE) ? ph - PH_ONE : '0;
   endfunction

   lir_lane #(.FRAC_BITS(FRAC_BITS), .PH_W(PH_W)) u_lane_left (
      .prev  (prev_left_ff),
      .cur   (cur_left_ff),
      .phase (phase_ff),
      .quot  (quot_left)
   );

   lir_lane #(.FRAC_BITS(FRAC_BITS), .PH_W(PH_W)) u_lane_right (
      .prev  (prev_right_ff),
      .cur   (cur_right_ff),
      .phase (phase_ff),
      .quot  (quot_right)
   );

   lir_merge u_merge (
      .quot_left  (quot_left),
      .quot_right (quot_right),
      .stereo     (stereo_ff),
      .last       (last),
      .word       (rsp_word_in)
   );

   always_comb begin
      sum         = SUM_W'(phase_ff) + SUM_W'(step_ff);
      phase_sat   = (sum > SUM_W'(PH_MAX)) ? PH_MAX : sum[PH_W-1:0];
      phase_whole = (phase_ff >= PH_ONE);
      last        = (phase_sat >= PH_ONE) || (cnt_ff == CNT_END);
      req_take    = req_port.valid && req_port.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && !phase_whole) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit && last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_port.ready = 1'b0;
      emit           = 1'b0;
      case (state_ff)
         ST_IDLE: req_port.ready = 1'b1;
         ST_RUN:  emit = !rsp_valid_ff || rsp_port.ready;
         default: begin
            req_port.ready = 1'b0;
            emit           = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      step_in       = step_ff;
      stereo_in     = stereo_ff;
      phase_in      = phase_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      cnt_in        = cnt_ff;

      if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            CSR_PHASE_STEP:  step_in   = csr_port.data[STEP_W-1:0];
            CSR_STEREO_MODE: stereo_in = csr_port.data[0];
            default: ;
         endcase
      end

      if (req_take) begin
         cur_left_in  = req_port.left_sample;
         cur_right_in = req_port.right_sample;
         cnt_in       = '0;
         // phase at or above one: the frame is skipped with no output
         if (phase_whole) begin
            phase_in     = phase_ff - PH_ONE;
            prev_left_in = req_port.left_sample;
            if (stereo_ff) begin
               prev_right_in = req_port.right_sample;
            end
         end
      end

      if (emit) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            phase_in     = wrap_phase(phase_sat);
            prev_left_in = cur_left_ff;
            if (stereo_ff) begin
               prev_right_in = cur_right_ff;
            end
         end else begin
            phase_in = phase_sat;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_RESET;
         stereo_ff     <= 1'b1;
         phase_ff      <= '0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         stereo_ff     <= stereo_in;
         phase_ff      <= phase_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff  <= cur_left_in;
      cur_right_ff <= cur_right_in;
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign csr_port.ready     = 1'b1;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_left  = rsp_word_ff.out_left;
   assign rsp_port.out_right = rsp_word_ff.out_right;
   assign rsp_port.run_last  = rsp_word_ff.run_last;
endmodule

// ===== rtl/lir_lane.sv =====
// lir_lane: one channel of the interpolator, prev + (cur - prev) * phase
// scaled down by the fraction width and truncated toward zero; depends on lir_pkg
module lir_lane #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF,
   parameter int PH_W      = FRAC_BITS + 4
) (
   input  logic signed [lir_pkg::SAMPLE_W-1:0] prev,
   input  logic signed [lir_pkg::SAMPLE_W-1:0] cur,
   input  logic        [PH_W-1:0]              phase,
   output logic signed [lir_pkg::Q_W-1:0]      quot
);
   import lir_pkg::*;

   localparam int PROD_W = SAMPLE_W + PH_W + 2;
   localparam int NUM_W  = SAMPLE_W + PH_W + 3;
   localparam logic [NUM_W-1:0] BIAS = NUM_W'({FRAC_BITS{1'b1}});

   logic signed [SAMPLE_W:0]   diff;
   logic signed [PH_W:0]       ph_s;
   logic signed [PROD_W-1:0]   prod;
   logic signed [NUM_W-1:0]    base;
   logic signed [NUM_W-1:0]    num;
   logic signed [NUM_W-1:0]    adj;

   always_comb begin
      diff = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
      ph_s = {1'b0, phase};
      prod = diff * ph_s;
      base = NUM_W'(prev) <<< FRAC_BITS;
      num  = base + NUM_W'(prod);
      // negative values round up so the shift truncates toward zero
      adj  = num + (num[NUM_W-1] ? BIAS : '0);
      quot = adj[NUM_W-1:FRAC_BITS];
   end
endmodule

// ===== rtl/lir_merge.sv =====
// lir_merge: clamps the lane quotients to 16 bits and packs the result word
// depends on lir_pkg
module lir_merge (
   input  logic signed [lir_pkg::Q_W-1:0] quot_left,
   input  logic signed [lir_pkg::Q_W-1:0] quot_right,
   input  logic                           stereo,
   input  logic                           last,
   output lir_pkg::rsp_word_type          word
);
   import lir_pkg::*;

   localparam logic signed [Q_W-1:0] SAT_HI =
      {{(Q_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] SAT_LO =
      {{(Q_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   function automatic logic signed [SAMPLE_W-1:0] clamp(input logic signed [Q_W-1:0] q);
      logic signed [SAMPLE_W-1:0] r;
      if (q > SAT_HI) begin
         r = SAT_HI[SAMPLE_W-1:0];
      end else if (q < SAT_LO) begin
         r = SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = q[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      word.out_left  = clamp(quot_left);
      word.out_right = stereo ? clamp(quot_right) : '0;
      word.run_last  = last;
   end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for linear_interp_resampler_top; an in-bench phase accumulator
// model predicts every result word, which a checker compares as it leaves the block
// depends on lir_pkg and the lir_req_if, lir_rsp_if and lir_csr_if interfaces
module tb;
   import lir_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int RUN_CAP     = MAX_RUN_DEF;
   localparam int PH_W        = FRAC + 4;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT    = 19;
   localparam int PRINT_CAP   = 50;

   localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << FRAC;
   localparam logic [PH_W-1:0] PHASE_MAX = '1;
   localparam longint SAMPLE_MAX = 32767;
   localparam longint SAMPLE_MIN = -32768;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   logic clock = 1'b0;
   logic reset = 1'b1;

   lir_req_if req_ch ();
   lir_rsp_if rsp_ch ();
   lir_csr_if csr_ch ();

   linear_interp_resampler_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // model state and configuration
   logic [STEP_W-1:0]          step_q16;
   logic                       stereo_on;
   logic signed [SAMPLE_W-1:0] prev_left;
   logic signed [SAMPLE_W-1:0] prev_right;
   logic [PH_W-1:0]            phase_acc;

   rsp_word_type expected_words[$];

   int err_count    = 0;
   int stall_cycles = 0;
   int hold_left    = 0;
   int req_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;

   always #5 clock = ~clock;

   function automatic logic signed [SAMPLE_W-1:0] lerp_sample(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b,
      input logic [PH_W-1:0]            ph
   );
      longint num;
      longint q;
      num = longint'(a) * (longint'(1) << FRAC) + (longint'(b) - longint'(a)) * longint'(ph);
      // signed division truncates toward zero
      q = num / (longint'(1) << FRAC);
      if (q > SAMPLE_MAX) begin
         q = SAMPLE_MAX;
      end else if (q < SAMPLE_MIN) begin
         q = SAMPLE_MIN;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   function automatic void predict_frame(
      input logic signed [SAMPLE_W-1:0] left,
      input logic signed [SAMPLE_W-1:0] right
   );
      rsp_word_type  run_words[RUN_CAP];
      int            n;
      logic [PH_W:0] sum;
      n = 0;
      while (phase_acc < PHASE_ONE && n < RUN_CAP) begin
         run_words[n].out_left  = lerp_sample(prev_left, left, phase_acc);
         run_words[n].out_right = stereo_on ? lerp_sample(prev_right, right, phase_acc) : '0;
         run_words[n].run_last  = 1'b0;
         n++;
         sum = {1'b0, phase_acc} + {1'b0, step_q16};
         phase_acc = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[PH_W-1:0];
      end
      if (n > 0) begin
         run_words[n-1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_words.push_back(run_words[i]);
      end
      // a run cut by the cap leaves the phase below one, which clears it
      phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : '0;
      prev_left = left;
      if (stereo_on) begin
         prev_right = right;
      end
   endfunction

   function automatic void apply_csr(
      input logic [CSR_IDX_W-1:0]  index,
      input logic [CSR_DATA_W-1:0] data
   );
      if (index == CSR_PHASE_STEP) begin
         step_q16 = data[STEP_W-1:0];
      end else if (index == CSR_STEREO_MODE) begin
         stereo_on = data[0];
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            return 16'sh8000;
         end
         1: begin
            return 16'sh7fff;
         end
         2: begin
            return 16'sh0000;
         end
         3: begin
            return 16'shffff;
         end
         default: begin
            return SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   // stereo flag in bit 0, noise in the bits above it
   function automatic logic [CSR_DATA_W-1:0] mode_data(input logic stereo);
      logic [CSR_DATA_W-1:0] d;
      d    = CSR_DATA_W'($urandom);
      d[0] = stereo;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < PRINT_CAP) begin
         $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      end
      err_count++;
   endtask

   task automatic send_frame(
      input logic signed [SAMPLE_W-1:0] left,
      input logic signed [SAMPLE_W-1:0] right
   );
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= left;
      req_ch.right_sample <= right;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      predict_frame(left, right);
   endtask

   task automatic write_csr(
      input logic [CSR_IDX_W-1:0]  index,
      input logic [CSR_DATA_W-1:0] data
   );
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      apply_csr(index, data);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // stop offering frames and let every expected word drain out
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic test_reset_state();
      send_frame(16'sh7fff, 16'sh8000);
      send_frame(16'sh8000, 16'sh7fff);
      send_frame(16'sh0000, 16'shffff);
   endtask

   task automatic test_interp_truncation();
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'('h04000));
      // small negative fractions must truncate to zero
      send_frame(16'shffff, 16'sh0001);
      send_frame(16'sh7fff, 16'sh8000);
      send_frame(16'sh8000, 16'sh7fff);
   endtask

   task automatic test_run_cap();
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'('h01000));
      send_frame(pick_sample(), pick_sample());
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'(0));
      send_frame(pick_sample(), pick_sample());
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'(1));
      send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_skip_frames();
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'('h20000));
      repeat (4) send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_mono_mode();
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'('h08000));
      write_csr(CSR_STEREO_MODE, mode_data(1'b0));
      send_frame(pick_sample(), pick_sample());
      send_frame(pick_sample(), pick_sample());
      // back to stereo with the right channel history left stale
      quiesce();
      write_csr(CSR_STEREO_MODE, mode_data(1'b1));
      send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_backpressure();
      quiesce();
      write_csr(CSR_PHASE_STEP, CSR_DATA_W'('h01000));
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (6) send_frame(pick_sample(), pick_sample());
   endtask

   task automatic test_random_streams();
      logic [STEP_W-1:0] step;
      for (int ph = 0; ph < 8; ph++) begin
         quiesce();
         case (ph)
            0: begin
               step = STEP_W'(4096);
            end
            1: begin
               step = STEP_W'(524288);
            end
            3: begin
               step = STEP_W'('h18000);
            end
            4: begin
               // large step on a fractional phase saturates the accumulator
               step = '1;
            end
            default: begin
               step = STEP_W'($urandom_range(4096, 98304));
            end
         endcase
         write_csr(CSR_PHASE_STEP, step);
         write_csr(CSR_STEREO_MODE, mode_data(ph != 1 && $urandom_range(0, 3) != 0));
         if (ph == 0) begin
            write_csr(CSR_SPARE_2, CSR_DATA_W'($urandom));
            write_csr(CSR_SPARE_3, CSR_DATA_W'($urandom));
         end
         req_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         rsp_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         repeat (18) send_frame(pick_sample(), pick_sample());
      end
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_ch.out_left, 0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_ch.out_left !== want.out_left) begin
               report_mismatch("out_left", rsp_ch.out_left, want.out_left);
            end
            if (rsp_ch.out_right !== want.out_right) begin
               report_mismatch("out_right", rsp_ch.out_right, want.out_right);
            end
            if (rsp_ch.run_last !== want.run_last) begin
               report_mismatch("run_last", rsp_ch.run_last, want.run_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $realtime, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.left_sample  = '0;
      req_ch.right_sample = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      step_q16            = STEP_RESET;
      stereo_on           = 1'b1;
      prev_left           = '0;
      prev_right          = '0;
      phase_acc           = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_interp_truncation();
      test_run_cap();
      test_skip_frames();
      test_mono_mode();
      test_backpressure();
      test_random_streams();

      quiesce();
      repeat (20) @(negedge clock);
      if (expected_words.size() != 0) begin
         report_mismatch("words never delivered", 0, expected_words.size());
      end
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lir_pkg.sv
rtl/lir_req_if.sv
rtl/lir_rsp_if.sv
rtl/lir_csr_if.sv
rtl/lir_lane.sv
rtl/lir_merge.sv
rtl/linear_interp_resampler_top.sv
test/tb.sv
